// File: rtl/mpd_pkg.sv
// Shared types, constants and codes for the memoized pair distance unit.
package mpd_pkg;

  localparam int MAX_POINTS_DEF    = 64;
  localparam int MAX_DIM_DEF       = 4;
  localparam int CACHE_ENTRIES_DEF = 2080;

  localparam int POINT_W  = 6;
  localparam int AXIS_W   = 2;
  localparam int COORD_W  = 24;
  localparam int DIST_W   = 26;
  localparam int ROOT_W   = 25;
  localparam int SUM_W    = 50;
  localparam int SQ_W     = 48;
  localparam int PCOUNT_W = 7;
  localparam int DIM_W    = 3;
  localparam int CFG_W    = 7;
  localparam int CIDX_W   = 1;
  localparam int TRI_W    = 12;
  localparam int EPOCH_W  = 4;
  localparam int PAIR_MAX = 2080;
  localparam int PTS_MAX  = 64;

  localparam logic [CIDX_W-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_DIMENSION   = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_CACHED   = 2'd2,
    CMD_UNCACHED = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DECODE,
    ST_CLR_PASS,
    ST_CACHE_CHK,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_SQUARE,
    ST_ACC,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_CACHE_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic start;
    logic coord_wr;
    logic epoch_inc;
    logic clr_step;
    logic load_hit;
    logic sel_b;
    logic cap_a;
    logic cap_diff;
    logic cap_sq;
    logic acc;
    logic sqrt_start;
    logic cap_root;
    logic cache_wr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic legal_a;
    logic legal_b;
    logic axis_ok;
    logic in_range;
    logic hit;
    logic k_last;
    logic dim_zero;
    logic clr_last;
    logic epoch_last;
    logic sqrt_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/mpd_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module mpd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mpd_pkg::SUM_W-1:0]   radicand_i,
  output logic [mpd_pkg::ROOT_W-1:0]  root_o,
  output logic                        done_o
);
  import mpd_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [SUM_W-1:0]  x_q, x_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], x_q[SUM_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: rtl/mpd_datapath.sv
// Datapath: request registers, coordinate and cache memories, accumulator and result register.
module mpd_datapath #(
  parameter int MAX_POINTS    = mpd_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIM       = mpd_pkg::MAX_DIM_DEF,
  parameter int CACHE_ENTRIES = mpd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpd_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [mpd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [1:0]                   command_i,
  input  logic [mpd_pkg::POINT_W-1:0]  point_a_i,
  input  logic [mpd_pkg::POINT_W-1:0]  point_b_i,
  input  logic [mpd_pkg::AXIS_W-1:0]   axis_i,
  input  logic signed [mpd_pkg::COORD_W-1:0] coord_value_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [mpd_pkg::DIST_W-1:0]   distance_o,
  output logic                         from_cache_o,
  output logic                         status_o,
  input  mpd_pkg::dp_cmd_t             cmd_i,
  output mpd_pkg::dp_stat_t            stat_o
);
  import mpd_pkg::*;

  localparam int PTS         = (MAX_POINTS < PTS_MAX) ? MAX_POINTS : PTS_MAX;
  localparam int CS_DEPTH    = PTS * MAX_DIM;
  localparam int CS_AW       = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;
  localparam int CACHE_DEPTH = (CACHE_ENTRIES < PAIR_MAX) ? CACHE_ENTRIES : PAIR_MAX;
  localparam int CAW         = $clog2(CACHE_DEPTH);
  localparam int KW          = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CE_W        = EPOCH_W + DIST_W;

  logic [COORD_W-1:0] coord_mem [CS_DEPTH];
  logic [CE_W-1:0]    cache_mem [CACHE_DEPTH];

  logic [PCOUNT_W-1:0] pcount_q;
  logic [DIM_W-1:0]    dim_q;
  cmd_e                cmd_q;
  logic [POINT_W-1:0]  pa_q, pb_q;
  logic [AXIS_W-1:0]   axis_q;
  logic [COORD_W-1:0]  val_q;
  logic [COORD_W-1:0]  coord_rd_q;
  logic [CE_W-1:0]     cache_rd_q;
  logic signed [COORD_W-1:0] ca_q;
  logic [COORD_W-1:0]  diff_q;
  logic [SQ_W-1:0]     sq_q;
  logic [SUM_W-1:0]    sum_q;
  logic [KW-1:0]       k_q;
  logic [CAW-1:0]      clr_cnt_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [DIST_W-1:0]   res_dist_q;
  logic                res_hit_q, res_err_q;
  logic                out_valid_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic                out_hit_q, out_err_q;

  logic                legal_a, legal_b, err;
  logic [POINT_W-1:0]  pi, pj;
  logic [TRI_W:0]      tri_full;
  logic [TRI_W-1:0]    pair_idx;
  logic [CAW-1:0]      cache_addr;
  logic [DIM_W-1:0]    dim_eff;
  logic [CS_AW-1:0]    rd_addr, wr_addr;
  logic [POINT_W-1:0]  rd_point;
  logic signed [COORD_W:0] diff;
  logic [ROOT_W-1:0]   root;
  logic                sqrt_done;

  assign legal_a = ({1'b0, pa_q} < pcount_q) && (32'(pa_q) < 32'(MAX_POINTS));
  assign legal_b = ({1'b0, pb_q} < pcount_q) && (32'(pb_q) < 32'(MAX_POINTS));

  always_comb begin
    case (cmd_q)
      CMD_WRITE: err = !legal_a;
      CMD_CLEAR: err = 1'b0;
      default:   err = !(legal_a && legal_b);
    endcase
  end

  assign pi         = (pa_q < pb_q) ? pa_q : pb_q;
  assign pj         = (pa_q < pb_q) ? pb_q : pa_q;
  assign tri_full   = (TRI_W + 1)'(pj) * (TRI_W + 1)'({1'b0, pj} + 7'd1);
  assign pair_idx   = tri_full[TRI_W:1] + TRI_W'(pi);
  assign cache_addr = pair_idx[CAW-1:0];
  assign dim_eff    = (32'(dim_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q;

  assign rd_point = cmd_i.sel_b ? pb_q : pa_q;
  assign rd_addr  = CS_AW'(32'(rd_point) * MAX_DIM + 32'(k_q));
  assign wr_addr  = CS_AW'(32'(pa_q) * MAX_DIM + 32'(axis_q));
  assign diff     = {ca_q[COORD_W-1], ca_q} -
                    {coord_rd_q[COORD_W-1], coord_rd_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_wr) begin
      coord_mem[wr_addr] <= val_q;
    end
    coord_rd_q <= coord_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      cache_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.cache_wr) begin
      cache_mem[cache_addr] <= {epoch_q, res_dist_q};
    end
    cache_rd_q <= cache_mem[cache_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q    <= PCOUNT_W'(64);
      dim_q       <= DIM_W'(3);
      clr_cnt_q   <= '0;
      epoch_q     <= EPOCH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POINT_COUNT: pcount_q <= cfg_wdata_i[PCOUNT_W-1:0];
          CFG_DIMENSION:   dim_q    <= cfg_wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        if (clr_cnt_q == CAW'(CACHE_DEPTH - 1)) begin
          clr_cnt_q <= '0;
          epoch_q   <= EPOCH_W'(1);
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end else if (cmd_i.epoch_inc) begin
        epoch_q <= epoch_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= cmd_e'(command_i);
      pa_q   <= point_a_i;
      pb_q   <= point_b_i;
      axis_q <= axis_i;
      val_q  <= coord_value_i;
    end
    if (cmd_i.start) begin
      res_dist_q <= '0;
      res_hit_q  <= 1'b0;
      res_err_q  <= err;
      sum_q      <= '0;
      k_q        <= '0;
    end else begin
      if (cmd_i.load_hit) begin
        res_dist_q <= cache_rd_q[DIST_W-1:0];
        res_hit_q  <= 1'b1;
      end else if (cmd_i.cap_root) begin
        res_dist_q <= DIST_W'(root);
      end
      if (cmd_i.acc) begin
        sum_q <= sum_q + SUM_W'(sq_q);
        k_q   <= k_q + 1'b1;
      end
    end
    if (cmd_i.cap_a) begin
      ca_q <= coord_rd_q;
    end
    if (cmd_i.cap_diff) begin
      diff_q <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    end
    if (cmd_i.cap_sq) begin
      sq_q <= diff_q * diff_q;
    end
    if (cmd_i.load_out) begin
      out_dist_q <= res_dist_q;
      out_hit_q  <= res_hit_q;
      out_err_q  <= res_err_q;
    end
  end

  mpd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (sum_q),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.legal_a    = legal_a;
    stat_o.legal_b    = legal_b;
    stat_o.axis_ok    = 32'(axis_q) < 32'(MAX_DIM);
    stat_o.in_range   = 32'(pair_idx) < 32'(CACHE_ENTRIES);
    stat_o.hit        = cache_rd_q[CE_W-1 -: EPOCH_W] == epoch_q;
    stat_o.k_last     = (DIM_W'(k_q) + DIM_W'(1)) == dim_eff;
    stat_o.dim_zero   = dim_eff == '0;
    stat_o.clr_last   = clr_cnt_q == CAW'(CACHE_DEPTH - 1);
    stat_o.epoch_last = &epoch_q;
    stat_o.sqrt_done  = sqrt_done;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = out_dist_q;
  assign from_cache_o = out_hit_q;
  assign status_o     = out_err_q;

endmodule

// File: rtl/mpd_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module mpd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpd_pkg::dp_stat_t  stat_i,
  output mpd_pkg::dp_cmd_t   cmd_o
);
  import mpd_pkg::*;

  state_e state_q, state_d;
  logic   compute_path;
  state_e compute_entry;

  assign compute_entry = stat_i.dim_zero ? ST_SQRT : ST_RD_A;
  assign compute_path  = (stat_i.cmd == CMD_CACHED) || (stat_i.cmd == CMD_UNCACHED);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT_CLR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat_i.cmd)
          CMD_WRITE: state_d = ST_FINISH;
          CMD_CLEAR: state_d = stat_i.epoch_last ? ST_CLR_PASS : ST_FINISH;
          default: begin
            if (!(stat_i.legal_a && stat_i.legal_b)) begin
              state_d = ST_FINISH;
            end else if (stat_i.cmd == CMD_CACHED && stat_i.in_range) begin
              state_d = ST_CACHE_CHK;
            end else begin
              state_d = compute_entry;
            end
          end
        endcase
      end
      ST_CLR_PASS: begin
        if (stat_i.clr_last) state_d = ST_FINISH;
      end
      ST_CACHE_CHK: state_d = stat_i.hit ? ST_FINISH : compute_entry;
      ST_RD_A:      state_d = ST_RD_B;
      ST_RD_B:      state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_ACC;
      ST_ACC:       state_d = stat_i.k_last ? ST_SQRT : ST_RD_A;
      ST_SQRT:      state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (stat_i.sqrt_done) begin
          if (stat_i.cmd == CMD_CACHED && stat_i.in_range) state_d = ST_CACHE_WR;
          else state_d = ST_FINISH;
        end
      end
      ST_CACHE_WR: state_d = ST_FINISH;
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_INIT_CLR:  cmd_o.clr_step = 1'b1;
      ST_IDLE:      cmd_o.latch = in_valid_i;
      ST_DECODE: begin
        cmd_o.start     = 1'b1;
        cmd_o.coord_wr  = (stat_i.cmd == CMD_WRITE) && stat_i.legal_a && stat_i.axis_ok;
        cmd_o.epoch_inc = (stat_i.cmd == CMD_CLEAR) && !stat_i.epoch_last;
      end
      ST_CLR_PASS:  cmd_o.clr_step = 1'b1;
      ST_CACHE_CHK: cmd_o.load_hit = stat_i.hit && compute_path;
      ST_RD_A:      cmd_o.sel_b = 1'b0;
      ST_RD_B: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.cap_a = 1'b1;
      end
      ST_DIFF:      cmd_o.cap_diff = 1'b1;
      ST_SQUARE:    cmd_o.cap_sq = 1'b1;
      ST_ACC:       cmd_o.acc = 1'b1;
      ST_SQRT:      cmd_o.sqrt_start = 1'b1;
      ST_SQRT_WAIT: cmd_o.cap_root = stat_i.sqrt_done;
      ST_CACHE_WR:  cmd_o.cache_wr = 1'b1;
      ST_FINISH:    cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/memoized_pair_distance_unit.sv
// Top level of the memoized pair distance unit: controller, datapath and ports.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | command, point_a, point_b, axis, coord_value
//   out     | output    | out_valid_o / out_stall_i | distance, from_cache, status
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// After acceptance in_stall_o stays high until the request is done: a write, clear
// or rejected request goes through decode and finish, a cache hit through a cache check
// as well, and a miss through one coordinate memory read per operand per axis, the
// 25-step bit-serial square root and, for a cached query in cache range, a cache write.
// After reset a clearing pass over the cache memory (CACHE_ENTRIES entries, 2080 by
// default) runs with in_stall_o high; every fifteenth clear request runs it again.
// A stalled result sits in the output register while the next request is worked on.
module memoized_pair_distance_unit #(
  parameter int MAX_POINTS    = mpd_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIM       = mpd_pkg::MAX_DIM_DEF,
  parameter int CACHE_ENTRIES = mpd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpd_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [mpd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [mpd_pkg::POINT_W-1:0]  point_a_i,
  input  logic [mpd_pkg::POINT_W-1:0]  point_b_i,
  input  logic [mpd_pkg::AXIS_W-1:0]   axis_i,
  input  logic signed [mpd_pkg::COORD_W-1:0] coord_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpd_pkg::DIST_W-1:0]   distance_o,
  output logic                         from_cache_o,
  output logic                         status_o
);
  import mpd_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  mpd_datapath #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_DIM       (MAX_DIM),
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .point_a_i     (point_a_i),
    .point_b_i     (point_b_i),
    .axis_i        (axis_i),
    .coord_value_i (coord_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .distance_o    (distance_o),
    .from_cache_o  (from_cache_o),
    .status_o      (status_o),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat)
  );

endmodule

// File: rtl/mpd_checker.sv
// Port-level checker for the memoized pair distance unit and its bind.
module mpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mpd_pkg::DIST_W-1:0]  distance_o,
  input logic                        from_cache_o,
  input logic                        status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(distance_o) && $stable(from_cache_o)
      && $stable(status_o))
    else $error("Stalled result payload changed.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> distance_o == '0 && !from_cache_o)
    else $error("Rejected request carries a distance or a cache hit.");

  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("Requests accepted before the cache clearing pass.");

endmodule

bind memoized_pair_distance_unit mpd_checker u_mpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .distance_o   (distance_o),
  .from_cache_o (from_cache_o),
  .status_o     (status_o)
);

// File: tb/sv/tb_memoized_pair_distance_unit.sv
// Self-checking testbench for the memoized pair distance unit with a built-in predictor.
`timescale 1ns / 100ps

module tb_memoized_pair_distance_unit;
  import mpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    cmd_e                 cmd;
    logic [POINT_W-1:0]   a;
    logic [POINT_W-1:0]   b;
    logic [AXIS_W-1:0]    axis;
    logic [COORD_W-1:0]   val;
  } request_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              hit;
    logic              status;
  } reply_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] command_i;
  logic [POINT_W-1:0] point_a_i;
  logic [POINT_W-1:0] point_b_i;
  logic [AXIS_W-1:0] axis_i;
  logic signed [COORD_W-1:0] coord_value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [DIST_W-1:0] distance_o;
  logic from_cache_o;
  logic status_o;

  memoized_pair_distance_unit uut (.*);

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       errors;
  int       idle_cycles;
  int       send_gap;
  int       stall_left;

  // Predictor copy of the block state and registers.
  logic [COORD_W-1:0] coords[PTS_MAX][MAX_DIM_DEF];
  logic [DIST_W-1:0]  dist_memo[PAIR_MAX];
  logic               memo_valid[PAIR_MAX];
  int                 model_points;
  int                 model_dim;

  // Generation-time view: which coordinates have been written so far.
  logic               written[PTS_MAX][MAX_DIM_DEF];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] place;
    res = 0;
    place = 64'd1 << 62;
    while (place > x) place = place >> 2;
    while (place != 0) begin
      if (x >= res + place) begin
        x = x - (res + place);
        res = (res >> 1) + place;
      end else begin
        res = res >> 1;
      end
      place = place >> 2;
    end
    return res;
  endfunction

  function automatic logic point_ok(int p);
    return p < model_points && p < PTS_MAX;
  endfunction

  function automatic logic [DIST_W-1:0] pair_distance(int i, int j);
    int d;
    longint ca, cb, diff;
    logic [63:0] sum;
    sum = 0;
    d = model_dim > MAX_DIM_DEF ? MAX_DIM_DEF : model_dim;
    for (int k = 0; k < d; k++) begin
      ca = {{40{coords[i][k][COORD_W-1]}}, coords[i][k]};
      cb = {{40{coords[j][k][COORD_W-1]}}, coords[j][k]};
      diff = ca - cb;
      if (diff < 0) diff = -diff;
      sum = sum + 64'(diff) * 64'(diff);
    end
    return DIST_W'(int_root(sum));
  endfunction

  function automatic reply_t model_request(request_t rq);
    reply_t rp;
    int i, j, idx;
    rp = '{distance: '0, hit: 1'b0, status: 1'b0};
    case (rq.cmd)
      CMD_WRITE: begin
        if (!point_ok(rq.a)) rp.status = 1'b1;
        else coords[rq.a][rq.axis] = rq.val;
      end
      CMD_CLEAR: begin
        foreach (memo_valid[n]) memo_valid[n] = 1'b0;
      end
      default: begin
        if (!point_ok(rq.a) || !point_ok(rq.b)) begin
          rp.status = 1'b1;
        end else begin
          i = rq.a < rq.b ? rq.a : rq.b;
          j = rq.a < rq.b ? rq.b : rq.a;
          idx = i + j * (j + 1) / 2;
          if (rq.cmd == CMD_CACHED && idx < PAIR_MAX) begin
            if (memo_valid[idx]) begin
              rp.distance = dist_memo[idx];
              rp.hit = 1'b1;
            end else begin
              rp.distance = pair_distance(i, j);
              dist_memo[idx] = rp.distance;
              memo_valid[idx] = 1'b1;
            end
          end else begin
            rp.distance = pair_distance(i, j);
          end
        end
      end
    endcase
    return rp;
  endfunction

  function automatic int live_points();
    return model_points > PTS_MAX ? PTS_MAX : model_points;
  endfunction

  function automatic void push_write(int a, int axis, logic [COORD_W-1:0] val);
    if (a < live_points()) written[a][axis] = 1'b1;
    pending_requests.push_back('{cmd: CMD_WRITE, a: POINT_W'(a), b: POINT_W'($urandom),
                                 axis: AXIS_W'(axis), val: val});
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h800000;
    if (r == 1) return 24'h7FFFFF;
    if (r < 5) return COORD_W'($urandom_range(0, 4095)) - 24'd2048;
    return COORD_W'($urandom);
  endfunction

  // Queries on legal points first write any coordinate that would be read unwritten.
  function automatic void push_query(cmd_e cmd, int a, int b);
    int d;
    d = model_dim > MAX_DIM_DEF ? MAX_DIM_DEF : model_dim;
    if (a < live_points() && b < live_points()) begin
      for (int k = 0; k < d; k++) begin
        if (!written[a][k]) push_write(a, k, rand_coord());
        if (!written[b][k]) push_write(b, k, rand_coord());
      end
    end
    pending_requests.push_back('{cmd: cmd, a: POINT_W'(a), b: POINT_W'(b),
                                 axis: AXIS_W'($urandom), val: COORD_W'($urandom)});
  endfunction

  function automatic int pick_point(int pool);
    int lim;
    lim = live_points();
    if (lim == 0 || $urandom_range(0, 6) == 0) return $urandom_range(0, PTS_MAX - 1);
    if (pool < lim && $urandom_range(0, 1) == 0) lim = pool;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic void fill_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 28) push_write(pick_point(64), $urandom_range(0, 3), rand_coord());
      else if (r < 31) pending_requests.push_back('{cmd: CMD_CLEAR, a: POINT_W'($urandom),
                                                    b: POINT_W'($urandom),
                                                    axis: AXIS_W'($urandom),
                                                    val: COORD_W'($urandom)});
      else if (r < 80) push_query(CMD_CACHED, pick_point(6), pick_point(6));
      else push_query(CMD_UNCACHED, pick_point(64), pick_point(64));
    end
  endfunction

  task automatic cfg_write(logic [CIDX_W-1:0] idx, int data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POINT_COUNT) model_points = data;
    else model_dim = data;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    request_t rq, cur;
    logic take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= CMD_WRITE;
      point_a_i <= '0;
      point_b_i <= '0;
      axis_i <= '0;
      coord_value_i <= '0;
      send_gap <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        cur = '{cmd: cmd_e'(command_i), a: point_a_i, b: point_b_i, axis: axis_i,
                val: coord_value_i};
        expected_replies.push_back(model_request(cur));
      end
      if (!in_valid_i || take) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          rq = pending_requests.pop_front();
          command_i <= rq.cmd;
          point_a_i <= rq.a;
          point_b_i <= rq.b;
          axis_i <= rq.axis;
          coord_value_i <= rq.val;
          in_valid_i <= 1'b1;
          send_gap <= pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t ex;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply distance=%h hit=%b status=%b", $time, distance_o,
                   from_cache_o, status_o);
        end else begin
          ex = expected_replies.pop_front();
          if (distance_o !== ex.distance) begin
            errors++;
            $display("%0t: distance expected %h actual %h", $time, ex.distance, distance_o);
          end
          if (from_cache_o !== ex.hit) begin
            errors++;
            $display("%0t: from_cache expected %b actual %b", $time, ex.hit, from_cache_o);
          end
          if (status_o !== ex.status) begin
            errors++;
            $display("%0t: status expected %b actual %b", $time, ex.status, status_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= pick_pause();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else if (pending_requests.size() != 0 || expected_replies.size() != 0 || in_valid_i)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int pc_set[5] = '{1, 0, 127, 17, 64};
    int dim_set[5] = '{1, 4, 7, 0, 2};
    errors = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_POINT_COUNT;
    cfg_wdata_i = '0;
    model_points = 64;
    model_dim = 3;
    foreach (memo_valid[n]) memo_valid[n] = 1'b0;
    foreach (written[p, k]) written[p][k] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(CFG_POINT_COUNT, 64);
    cfg_write(CFG_DIMENSION, 3);

    for (int k = 0; k < 4; k++) begin
      push_write(0, k, 24'h800000);
      push_write(63, k, 24'h7FFFFF);
    end
    push_query(CMD_CACHED, 0, 63);
    push_query(CMD_CACHED, 0, 63);
    push_query(CMD_CACHED, 63, 0);
    push_query(CMD_UNCACHED, 63, 0);
    push_query(CMD_CACHED, 0, 0);
    push_write(0, 0, 24'h000000);
    push_query(CMD_CACHED, 63, 0);
    push_query(CMD_UNCACHED, 0, 63);
    pending_requests.push_back('{cmd: CMD_CLEAR, a: 6'h3F, b: 6'h3F, axis: 2'h3,
                                 val: 24'hFFFFFF});
    push_query(CMD_CACHED, 0, 63);
    push_query(CMD_CACHED, 63, 63);
    wait_drained();

    fill_random(170);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_POINT_COUNT, pc_set[ph]);
      cfg_write(CFG_DIMENSION, dim_set[ph]);
      fill_random(110);
      wait_drained();
    end

    if (errors == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
